FILE: rtl/qstd_pkg.sv
// ----------------------------------------------------------------------------
// qstd_pkg: shared types and constants for the smallest-three decoder
// Field layout of the packed word, Q1.15 decode constants and the payload
// structs that travel down the pipeline.
// ----------------------------------------------------------------------------
package qstd_pkg;

    // packed word layout
    localparam int WORD_W      = 48;
    localparam int FIELD_W     = 15;
    localparam int INDEX_W     = 2;
    localparam int INDEX_SHIFT = 45;
    localparam int A_SHIFT     = 30;
    localparam int B_SHIFT     = 15;
    localparam int C_SHIFT     = 0;

    // Q1.15 component and decode multiply
    localparam int COMP_W       = 16;
    localparam int MUL_W        = 20;
    localparam int DECODE_SHIFT = 20;
    localparam int PROD_W       = FIELD_W + MUL_W;
    localparam logic [MUL_W-1:0]  DECODE_MUL = 20'd741478;
    localparam logic [PROD_W-1:0] DECODE_RND = PROD_W'(1) << (DECODE_SHIFT - 1);
    localparam int COMP_BOUND   = 23171;

    // remainder and square root
    localparam int SQ_W       = 30;
    localparam int SUM_W      = 32;
    localparam int REM_W      = 31;
    localparam int ROOT_W     = 32;
    localparam int ROOT_STEPS = 16;
    localparam logic [SUM_W-1:0]  ONE_Q30  = SUM_W'(1) << 30;
    localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(32768);
    localparam logic [COMP_W-1:0] D_MAX    = 16'h7FFF;

    // slot codes for the rebuilt component
    localparam logic [INDEX_W-1:0] SLOT_ZERO  = 2'd0;
    localparam logic [INDEX_W-1:0] SLOT_ONE   = 2'd1;
    localparam logic [INDEX_W-1:0] SLOT_TWO   = 2'd2;
    localparam logic [INDEX_W-1:0] SLOT_THREE = 2'd3;

    // decoded components and slot index
    typedef struct packed {
        logic [INDEX_W-1:0]       idx;
        logic signed [COMP_W-1:0] a;
        logic signed [COMP_W-1:0] b;
        logic signed [COMP_W-1:0] c;
    } comp_item_t;

    // square root working item
    typedef struct packed {
        comp_item_t        comp;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_item_t;

endpackage

FILE: rtl/qstd_front.sv
// ----------------------------------------------------------------------------
// qstd_front: field decode, squaring and remainder
// Three register stages: decode the three fields to Q1.15, square them,
// then form the clamped Q2.30 remainder for the square root.
// ----------------------------------------------------------------------------
module qstd_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [qstd_pkg::WORD_W-1:0]        word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output qstd_pkg::root_item_t               out_item
);

    // field code to signed Q1.15, rounded to nearest
    function automatic logic signed [qstd_pkg::COMP_W-1:0] decode_field
        (input logic [qstd_pkg::FIELD_W-1:0] q);
        logic [qstd_pkg::FIELD_W-1:0] mag;
        logic [qstd_pkg::PROD_W-1:0]  prod;
        logic [qstd_pkg::COMP_W-1:0]  m;
        mag  = q[qstd_pkg::FIELD_W-1] ? {q[qstd_pkg::FIELD_W-2:0], 1'b1}
                                      : {~q[qstd_pkg::FIELD_W-2:0], 1'b1};
        prod = qstd_pkg::PROD_W'(mag) * qstd_pkg::PROD_W'(qstd_pkg::DECODE_MUL)
             + qstd_pkg::DECODE_RND;
        m    = {1'b0, prod[qstd_pkg::PROD_W-1:qstd_pkg::DECODE_SHIFT]};
        return q[qstd_pkg::FIELD_W-1] ? $signed(m) : -$signed(m);
    endfunction

    logic                          s1_valid_reg;
    qstd_pkg::comp_item_t          s1_item_reg;
    qstd_pkg::comp_item_t          s1_item_next;
    logic                          s1_ready;

    logic                          s2_valid_reg;
    qstd_pkg::comp_item_t          s2_item_reg;
    logic [qstd_pkg::SQ_W-1:0]     s2_sa_reg;
    logic [qstd_pkg::SQ_W-1:0]     s2_sb_reg;
    logic [qstd_pkg::SQ_W-1:0]     s2_sc_reg;
    logic [qstd_pkg::SQ_W-1:0]     s2_sa_next;
    logic [qstd_pkg::SQ_W-1:0]     s2_sb_next;
    logic [qstd_pkg::SQ_W-1:0]     s2_sc_next;
    logic signed [2*qstd_pkg::COMP_W-1:0] prod_a;
    logic signed [2*qstd_pkg::COMP_W-1:0] prod_b;
    logic signed [2*qstd_pkg::COMP_W-1:0] prod_c;
    logic                          s2_ready;

    logic                          s3_valid_reg;
    qstd_pkg::root_item_t          s3_item_reg;
    qstd_pkg::root_item_t          s3_item_next;
    logic [qstd_pkg::SUM_W-1:0]    sq_sum;
    logic                          s3_ready;

    // stall chain: a stage takes new data when empty or draining
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1: decode
    always_comb
    begin
        s1_item_next.idx = word[qstd_pkg::INDEX_SHIFT +: qstd_pkg::INDEX_W];
        s1_item_next.a   = decode_field(word[qstd_pkg::A_SHIFT +: qstd_pkg::FIELD_W]);
        s1_item_next.b   = decode_field(word[qstd_pkg::B_SHIFT +: qstd_pkg::FIELD_W]);
        s1_item_next.c   = decode_field(word[qstd_pkg::C_SHIFT +: qstd_pkg::FIELD_W]);
    end

    // stage 2: squares, each below 2^30
    always_comb
    begin
        prod_a     = s1_item_reg.a * s1_item_reg.a;
        prod_b     = s1_item_reg.b * s1_item_reg.b;
        prod_c     = s1_item_reg.c * s1_item_reg.c;
        s2_sa_next = prod_a[qstd_pkg::SQ_W-1:0];
        s2_sb_next = prod_b[qstd_pkg::SQ_W-1:0];
        s2_sc_next = prod_c[qstd_pkg::SQ_W-1:0];
    end

    // stage 3: remainder of one, clamped at zero
    always_comb
    begin
        sq_sum = qstd_pkg::SUM_W'(s2_sa_reg) + qstd_pkg::SUM_W'(s2_sb_reg)
               + qstd_pkg::SUM_W'(s2_sc_reg);
        s3_item_next.comp = s2_item_reg;
        s3_item_next.root = '0;
        if (sq_sum > qstd_pkg::ONE_Q30)
        begin
            s3_item_next.rem = '0;
        end
        else
        begin
            s3_item_next.rem = qstd_pkg::REM_W'(qstd_pkg::ONE_Q30 - sq_sum);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_item_reg <= s1_item_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_item_reg <= s1_item_reg;
            s2_sa_reg   <= s2_sa_next;
            s2_sb_reg   <= s2_sb_next;
            s2_sc_reg   <= s2_sc_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

FILE: rtl/qstd_root_stage.sv
// ----------------------------------------------------------------------------
// qstd_root_stage: one step of the digit-by-digit square root
// Settles one root bit per stage: trial subtract of root plus the stage's
// bit weight, then shift the partial root down.
// ----------------------------------------------------------------------------
module qstd_root_stage
#(
    parameter int STEP = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  qstd_pkg::root_item_t    in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output qstd_pkg::root_item_t    out_item
);

    localparam logic [qstd_pkg::ROOT_W-1:0] BIT_WT =
        qstd_pkg::ROOT_W'(1) << (2 * (qstd_pkg::ROOT_STEPS - 1 - STEP));

    logic                           valid_reg;
    qstd_pkg::root_item_t           item_reg;
    qstd_pkg::root_item_t           item_next;
    logic [qstd_pkg::ROOT_W-1:0]    trial;

    assign in_ready = !valid_reg || out_ready;

    // trial subtract
    always_comb
    begin
        trial          = in_item.root + BIT_WT;
        item_next.comp = in_item.comp;
        if (qstd_pkg::ROOT_W'(in_item.rem) >= trial)
        begin
            item_next.rem  = in_item.rem - qstd_pkg::REM_W'(trial);
            item_next.root = (in_item.root >> 1) + BIT_WT;
        end
        else
        begin
            item_next.rem  = in_item.rem;
            item_next.root = in_item.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/qstd_slot_out.sv
// ----------------------------------------------------------------------------
// qstd_slot_out: saturation and slot placement
// Clips the root at 32767, places it in the indexed slot and fills the
// other slots in order; this register drives the result ports.
// ----------------------------------------------------------------------------
module qstd_slot_out
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  qstd_pkg::root_item_t               in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [qstd_pkg::COMP_W-1:0] slot_zero,
    output logic signed [qstd_pkg::COMP_W-1:0] slot_one,
    output logic signed [qstd_pkg::COMP_W-1:0] slot_two,
    output logic signed [qstd_pkg::COMP_W-1:0] slot_three
);

    logic                               valid_reg;
    logic signed [qstd_pkg::COMP_W-1:0] s0_reg;
    logic signed [qstd_pkg::COMP_W-1:0] s1_reg;
    logic signed [qstd_pkg::COMP_W-1:0] s2_reg;
    logic signed [qstd_pkg::COMP_W-1:0] s3_reg;
    logic signed [qstd_pkg::COMP_W-1:0] s0_next;
    logic signed [qstd_pkg::COMP_W-1:0] s1_next;
    logic signed [qstd_pkg::COMP_W-1:0] s2_next;
    logic signed [qstd_pkg::COMP_W-1:0] s3_next;
    logic [qstd_pkg::COMP_W-1:0]        d_val;

    assign in_ready = !valid_reg || out_ready;

    // saturate and place
    always_comb
    begin
        if (in_item.root > qstd_pkg::ROOT_W'(qstd_pkg::D_MAX))
        begin
            d_val = qstd_pkg::D_MAX;
        end
        else
        begin
            d_val = in_item.root[qstd_pkg::COMP_W-1:0];
        end
        unique case (in_item.comp.idx)
            qstd_pkg::SLOT_ZERO:
            begin
                s0_next = $signed(d_val);
                s1_next = in_item.comp.a;
                s2_next = in_item.comp.b;
                s3_next = in_item.comp.c;
            end
            qstd_pkg::SLOT_ONE:
            begin
                s0_next = in_item.comp.a;
                s1_next = $signed(d_val);
                s2_next = in_item.comp.b;
                s3_next = in_item.comp.c;
            end
            qstd_pkg::SLOT_TWO:
            begin
                s0_next = in_item.comp.a;
                s1_next = in_item.comp.b;
                s2_next = $signed(d_val);
                s3_next = in_item.comp.c;
            end
            qstd_pkg::SLOT_THREE:
            begin
                s0_next = in_item.comp.a;
                s1_next = in_item.comp.b;
                s2_next = in_item.comp.c;
                s3_next = $signed(d_val);
            end
            default:
            begin
                s0_next = in_item.comp.a;
                s1_next = in_item.comp.b;
                s2_next = in_item.comp.c;
                s3_next = $signed(d_val);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign out_valid  = valid_reg;
    assign slot_zero  = s0_reg;
    assign slot_one   = s1_reg;
    assign slot_two   = s2_reg;
    assign slot_three = s3_reg;

endmodule

FILE: rtl/quaternion_smallest_three_decoder.sv
// Stages: 3 front stages, 16 square-root stages and 1 output register lie
// between word transfer and result valid. Throughput: one word per cycle
// unless the output stalls; the 16-stage root pipeline takes one root bit per
// stage, and every stage holds its item while the next one is full.
// Reset: rst_n clears all valid bits asynchronously; data registers keep
// whatever they hold and no state carries between words.
// ----------------------------------------------------------------------------
// quaternion_smallest_three_decoder: 48-bit smallest-three rotation decode
// Decodes three 15-bit fields to Q1.15, rebuilds the largest component by
// a pipelined integer square root and places it in the indexed slot.
// ----------------------------------------------------------------------------
module quaternion_smallest_three_decoder
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               word_valid,
    output logic                               word_ready,
    input  logic [qstd_pkg::WORD_W-1:0]        packed_word,
    output logic                               quat_valid,
    input  logic                               quat_ready,
    output logic signed [qstd_pkg::COMP_W-1:0] slot_zero,
    output logic signed [qstd_pkg::COMP_W-1:0] slot_one,
    output logic signed [qstd_pkg::COMP_W-1:0] slot_two,
    output logic signed [qstd_pkg::COMP_W-1:0] slot_three
);

    logic                 chain_valid [qstd_pkg::ROOT_STEPS+1];
    logic                 chain_ready [qstd_pkg::ROOT_STEPS+1];
    qstd_pkg::root_item_t chain_item  [qstd_pkg::ROOT_STEPS+1];

    // decode, square, remainder
    qstd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (word_valid),
        .in_ready  (word_ready),
        .word      (packed_word),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    // square root, one bit per stage
    for (genvar k = 0; k < qstd_pkg::ROOT_STEPS; k++)
    begin : g_root
        qstd_root_stage
        #(
            .STEP (k)
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_item  (chain_item[k+1])
        );
    end

    // saturation, slot placement, result register
    qstd_slot_out u_slot_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (chain_valid[qstd_pkg::ROOT_STEPS]),
        .in_ready   (chain_ready[qstd_pkg::ROOT_STEPS]),
        .in_item    (chain_item[qstd_pkg::ROOT_STEPS]),
        .out_valid  (quat_valid),
        .out_ready  (quat_ready),
        .slot_zero  (slot_zero),
        .slot_one   (slot_one),
        .slot_two   (slot_two),
        .slot_three (slot_three)
    );

    // a draining output must open the whole stall chain
    assert property (@(posedge clk) disable iff (!rst_n)
        quat_ready |-> word_ready)
        else $error("input stalled while the output drains");

    // remainder never exceeds one in Q2.30
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] |-> (qstd_pkg::SUM_W'(chain_item[0].rem) <= qstd_pkg::ONE_Q30))
        else $error("remainder above one");

    // finished root is at most 32768
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[qstd_pkg::ROOT_STEPS]
            |-> (chain_item[qstd_pkg::ROOT_STEPS].root <= qstd_pkg::ROOT_MAX))
        else $error("square root out of range");

    // decoded components stay within one over root two
    assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[qstd_pkg::ROOT_STEPS]
            |-> ($signed(chain_item[qstd_pkg::ROOT_STEPS].comp.a) <= qstd_pkg::COMP_BOUND
              && $signed(chain_item[qstd_pkg::ROOT_STEPS].comp.a) >= -qstd_pkg::COMP_BOUND
              && $signed(chain_item[qstd_pkg::ROOT_STEPS].comp.b) <= qstd_pkg::COMP_BOUND
              && $signed(chain_item[qstd_pkg::ROOT_STEPS].comp.b) >= -qstd_pkg::COMP_BOUND
              && $signed(chain_item[qstd_pkg::ROOT_STEPS].comp.c) <= qstd_pkg::COMP_BOUND
              && $signed(chain_item[qstd_pkg::ROOT_STEPS].comp.c) >= -qstd_pkg::COMP_BOUND))
        else $error("decoded component out of range");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for quaternion_smallest_three_decoder
// Sends packed rotation words through the valid/ready input channel, predicts
// each decoded quaternion in Q1.15, and compares every output transfer slot by
// slot in arrival order. A short table of directed words comes first, then
// random words with bursty idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_WORDS   = 750;
    localparam int CALM_TAIL      = 100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 60;
    localparam int DIR_ROWS       = 16;

    // four output slots of one rotation
    typedef struct {
        logic signed [qstd_pkg::COMP_W-1:0] s0;
        logic signed [qstd_pkg::COMP_W-1:0] s1;
        logic signed [qstd_pkg::COMP_W-1:0] s2;
        logic signed [qstd_pkg::COMP_W-1:0] s3;
    } quat_t;

    // one word to send, with a typed result where it is known up front
    typedef struct {
        logic [qstd_pkg::WORD_W-1:0] word;
        bit                          known;
        quat_t                       val;
    } word_row_t;

    // one pending result, tagged with the word that caused it
    typedef struct {
        logic [qstd_pkg::WORD_W-1:0] word;
        quat_t                       val;
    } pending_t;

    logic                               clk;
    logic                               rst_n       = 1'b0;
    logic                               word_valid  = 1'b0;
    logic                               word_ready;
    logic [qstd_pkg::WORD_W-1:0]        packed_word = '0;
    logic                               quat_valid;
    logic                               quat_ready  = 1'b0;
    logic signed [qstd_pkg::COMP_W-1:0] slot_zero;
    logic signed [qstd_pkg::COMP_W-1:0] slot_one;
    logic signed [qstd_pkg::COMP_W-1:0] slot_two;
    logic signed [qstd_pkg::COMP_W-1:0] slot_three;

    word_row_t dir_tab [DIR_ROWS];
    word_row_t stim_q [$];
    pending_t  pending_quat [$];
    word_row_t cur_row;
    pending_t  want;
    pending_t  head;

    int err_count    = 0;
    int words_sent   = 0;
    int quats_seen   = 0;
    int idle_cycles  = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int gap_odds     = 2;
    bit calm;

    quaternion_smallest_three_decoder dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .packed_word (packed_word),
        .quat_valid  (quat_valid),
        .quat_ready  (quat_ready),
        .slot_zero   (slot_zero),
        .slot_one    (slot_one),
        .slot_two    (slot_two),
        .slot_three  (slot_three)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // field code to Q1.15, rounded to nearest with halves away from zero
    function automatic logic signed [qstd_pkg::COMP_W-1:0] decode_component
        (input logic [qstd_pkg::FIELD_W-1:0] q);
        int                s;
        longint unsigned   mag;
        longint unsigned   prod;
        int                m;
        s    = 2 * int'(q) - 32767;
        mag  = 64'((s < 0) ? -s : s);
        prod = mag * 741478 + (64'd1 << 19);
        m    = int'(prod >> 20);
        return (s < 0) ? qstd_pkg::COMP_W'(-m) : qstd_pkg::COMP_W'(m);
    endfunction

    // floor of the square root, one result bit per trial
    function automatic logic [16:0] root_floor(input longint unsigned v);
        logic [16:0]     root;
        longint unsigned trial;
        root = '0;
        for (int k = 16; k >= 0; k--)
        begin
            trial = 64'(root | (17'd1 << k));
            if (trial * trial <= v)
                root = trial[16:0];
        end
        return root;
    endfunction

    // full decode of one packed word
    function automatic quat_t rebuild_quat(input logic [qstd_pkg::WORD_W-1:0] w);
        logic signed [qstd_pkg::COMP_W-1:0] a;
        logic signed [qstd_pkg::COMP_W-1:0] b;
        logic signed [qstd_pkg::COMP_W-1:0] c;
        logic signed [qstd_pkg::COMP_W-1:0] d;
        logic [16:0]                        root;
        longint                             rem;
        quat_t                              q;
        a    = decode_component(w[qstd_pkg::A_SHIFT +: qstd_pkg::FIELD_W]);
        b    = decode_component(w[qstd_pkg::B_SHIFT +: qstd_pkg::FIELD_W]);
        c    = decode_component(w[qstd_pkg::C_SHIFT +: qstd_pkg::FIELD_W]);
        rem  = (64'sd1 <<< 30) - (longint'(a) * a + longint'(b) * b + longint'(c) * c);
        if (rem < 0)
            rem = 0;
        root = root_floor(rem);
        d    = (root > qstd_pkg::D_MAX) ? qstd_pkg::D_MAX : qstd_pkg::COMP_W'(root);
        case (w[qstd_pkg::INDEX_SHIFT +: qstd_pkg::INDEX_W])
            qstd_pkg::SLOT_ZERO: q = '{d, a, b, c};
            qstd_pkg::SLOT_ONE:  q = '{a, d, b, c};
            qstd_pkg::SLOT_TWO:  q = '{a, b, d, c};
            default:             q = '{a, b, c, d};
        endcase
        return q;
    endfunction

    function automatic logic [qstd_pkg::WORD_W-1:0] make_word
        (input bit top, input logic [qstd_pkg::INDEX_W-1:0] idx,
         input logic [qstd_pkg::FIELD_W-1:0] a,
         input logic [qstd_pkg::FIELD_W-1:0] b,
         input logic [qstd_pkg::FIELD_W-1:0] c);
        return {top, idx, a, b, c};
    endfunction

    function automatic word_row_t fixed_row(input logic [qstd_pkg::WORD_W-1:0] w,
                                            input int s0, input int s1,
                                            input int s2, input int s3);
        word_row_t r;
        r.word  = w;
        r.known = 1'b1;
        r.val   = '{qstd_pkg::COMP_W'(s0), qstd_pkg::COMP_W'(s1),
                    qstd_pkg::COMP_W'(s2), qstd_pkg::COMP_W'(s3)};
        return r;
    endfunction

    function automatic word_row_t open_row(input logic [qstd_pkg::WORD_W-1:0] w);
        word_row_t r;
        r.word  = w;
        r.known = 1'b0;
        r.val   = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        return r;
    endfunction

    // field whose decoded size puts the sum of squares close to one
    function automatic logic [qstd_pkg::FIELD_W-1:0] edge_field();
        int off;
        off = 13377 + $urandom_range(0, 800) - 400;
        return $urandom_range(0, 1) ? qstd_pkg::FIELD_W'(16384 + off)
                                    : qstd_pkg::FIELD_W'(16383 - off);
    endfunction

    // field that decodes close to zero
    function automatic logic [qstd_pkg::FIELD_W-1:0] center_field();
        int off;
        off = $urandom_range(0, 300);
        return $urandom_range(0, 1) ? qstd_pkg::FIELD_W'(16384 + off)
                                    : qstd_pkg::FIELD_W'(16383 - off);
    endfunction

    task automatic report_mismatch(input string what, input logic [qstd_pkg::WORD_W-1:0] w,
                                   input int got, input int exp_val);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("error: %s word=%h got=%0d want=%0d", what, w, got, exp_val);
    endtask

    // stimulus build, reset and end of run
    initial
    begin
        // extremes, center codes, every slot, top bit
        dir_tab[0]  = fixed_row('0, 0, -23170, -23170, -23170);
        dir_tab[1]  = fixed_row(make_word(1'b0, qstd_pkg::SLOT_THREE,
                                          15'h7FFF, 15'h7FFF, 15'h7FFF),
                                23170, 23170, 23170, 0);
        dir_tab[2]  = fixed_row(make_word(1'b0, qstd_pkg::SLOT_ZERO,
                                          15'd16384, 15'd16384, 15'd16384),
                                32767, 1, 1, 1);
        dir_tab[3]  = fixed_row(make_word(1'b0, qstd_pkg::SLOT_ONE,
                                          15'd16384, 15'd16384, 15'd16384),
                                1, 32767, 1, 1);
        dir_tab[4]  = fixed_row(make_word(1'b0, qstd_pkg::SLOT_TWO,
                                          15'd16383, 15'd16383, 15'd16383),
                                -1, -1, 32767, -1);
        dir_tab[5]  = fixed_row(make_word(1'b1, qstd_pkg::SLOT_THREE,
                                          15'd16383, 15'd16383, 15'd16383),
                                -1, -1, -1, 32767);
        dir_tab[6]  = fixed_row({qstd_pkg::WORD_W{1'b1}}, 23170, 23170, 23170, 0);
        dir_tab[7]  = fixed_row(make_word(1'b1, qstd_pkg::SLOT_ZERO, 15'd0, 15'd0, 15'd0),
                                0, -23170, -23170, -23170);
        dir_tab[8]  = open_row(make_word(1'b0, qstd_pkg::SLOT_ONE,
                                         15'd0, 15'h7FFF, 15'd16384));
        dir_tab[9]  = open_row(make_word(1'b1, qstd_pkg::SLOT_TWO,
                                         15'h7FFF, 15'd0, 15'd16383));
        dir_tab[10] = open_row(make_word(1'b0, qstd_pkg::SLOT_ZERO,
                                         edge_field(), edge_field(), edge_field()));
        dir_tab[11] = open_row(make_word(1'b0, qstd_pkg::SLOT_ONE,
                                         edge_field(), edge_field(), edge_field()));
        dir_tab[12] = open_row(make_word(1'b1, qstd_pkg::SLOT_TWO,
                                         edge_field(), edge_field(), edge_field()));
        dir_tab[13] = open_row(make_word(1'b1, qstd_pkg::SLOT_THREE,
                                         edge_field(), edge_field(), edge_field()));
        dir_tab[14] = open_row(make_word(1'b0, qstd_pkg::SLOT_THREE,
                                         15'h5555, 15'h2AAA, 15'h7FFF));
        dir_tab[15] = open_row(make_word(1'b1, qstd_pkg::SLOT_ZERO,
                                         15'h2AAA, 15'h5555, 15'd1));
        for (int i = 0; i < DIR_ROWS; i++)
            stim_q = {stim_q, dir_tab[i]};

        // random words: raw, near-zero fields, and sums of squares near one
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            int pick;
            pick = $urandom_range(0, 9);
            if (pick < 4)
                stim_q = {stim_q, open_row(qstd_pkg::WORD_W'({$urandom, $urandom}))};
            else if (pick < 7)
                stim_q = {stim_q, open_row(make_word(1'($urandom_range(0, 1)),
                                                     qstd_pkg::INDEX_W'($urandom_range(0, 3)),
                                                     center_field(), center_field(),
                                                     center_field()))};
            else
                stim_q = {stim_q, open_row(make_word(1'($urandom_range(0, 1)),
                                                     qstd_pkg::INDEX_W'($urandom_range(0, 3)),
                                                     edge_field(), edge_field(),
                                                     edge_field()))};
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || pending_quat.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d words (%0d directed rows), %0d quaternions compared",
                 words_sent, DIR_ROWS, quats_seen);
        $display("mismatches: %0d, results still pending: %0d", err_count, pending_quat.size());
        if (err_count == 0 && pending_quat.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // no idling once the last stretch of words is reached
    assign calm = (stim_q.size() < CALM_TAIL);

    // word sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // transfer of the word on the port
            if (word_valid && word_ready)
            begin
                cur_row = stim_q.pop_front();
                want.word = cur_row.word;
                want.val  = cur_row.known ? cur_row.val : rebuild_quat(cur_row.word);
                pending_quat = {pending_quat, want};
                words_sent++;
                if (words_sent % 60 == 0)
                    gap_odds = $urandom_range(0, 3);
            end

            // next word or idle burst
            if (!word_valid || word_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    word_valid <= 1'b0;
                end
                else if (stim_q.size() == 0)
                    word_valid <= 1'b0;
                else if (!calm && $urandom_range(0, 7) < gap_odds)
                begin
                    send_gap = $urandom_range(1, 14) - 1;
                    word_valid <= 1'b0;
                end
                else
                begin
                    word_valid  <= 1'b1;
                    packed_word <= stim_q[0].word;
                end
            end
        end
    end

    // result receiver and compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (quat_valid && quat_ready)
            begin
                quats_seen++;
                if (pending_quat.size() == 0)
                    report_mismatch("result with nothing pending", '0, slot_zero, 0);
                else
                begin
                    head = pending_quat.pop_front();
                    if (slot_zero !== head.val.s0)
                        report_mismatch("slot_zero", head.word, slot_zero, head.val.s0);
                    if (slot_one !== head.val.s1)
                        report_mismatch("slot_one", head.word, slot_one, head.val.s1);
                    if (slot_two !== head.val.s2)
                        report_mismatch("slot_two", head.word, slot_two, head.val.s2);
                    if (slot_three !== head.val.s3)
                        report_mismatch("slot_three", head.word, slot_three, head.val.s3);
                end
            end

            // back-pressure bursts
            if (recv_gap > 0)
            begin
                recv_gap--;
                quat_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) < gap_odds)
            begin
                recv_gap = $urandom_range(1, 14) - 1;
                quat_ready <= 1'b0;
            end
            else
                quat_ready <= 1'b1;
        end
    end

    // cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((word_valid && word_ready) || (quat_valid && quat_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no transfer for %0d cycles, %0d results pending",
                 WATCHDOG_LIMIT, pending_quat.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/qstd_pkg.sv
rtl/qstd_front.sv
rtl/qstd_root_stage.sv
rtl/qstd_slot_out.sv
rtl/quaternion_smallest_three_decoder.sv
bench/tb_top.sv
